>>> rtl/link_slot_load_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Link slot load table: assertion macros
// Concurrent assertion helpers used by the RTL of the unit.
// ----------------------------------------------------------------------------
`ifndef LINK_SLOT_LOAD_TABLE_UNIT_DEFINES_SVH
`define LINK_SLOT_LOAD_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
// generic form: explicit clock and active-low reset
`define LSLT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// block clock and reset
`define LSLT_ASSERT(lbl, prop, msg) \
  `LSLT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define LSLT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define LSLT_ASSERT(lbl, prop, msg)
`endif

`endif

>>> rtl/lslt_pkg.sv
// ----------------------------------------------------------------------------
// Link slot load table package
// Field widths, beat layout, command codes and defaults of the block.
// ----------------------------------------------------------------------------
package lslt_pkg;

  localparam int unsigned NUM_LINKS_DEF = 64;
  localparam int unsigned NUM_SLOTS_DEF = 16;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned EDGE_W = 6;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned FLOW_W = 24;
  localparam int unsigned RES_W  = 25;

  // input beat layout
  localparam int unsigned IN_EDGE_LSB = 0;
  localparam int unsigned IN_SLOT_LSB = IN_EDGE_LSB + EDGE_W;
  localparam int unsigned IN_AMT_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_CAP_LSB  = IN_AMT_LSB + FLOW_W;
  localparam int unsigned IN_TDATA_W  = 64;

  // output beat layout
  localparam int unsigned OUT_GRANT_LSB = 0;
  localparam int unsigned OUT_REM_LSB   = OUT_GRANT_LSB + RES_W;
  localparam int unsigned OUT_BUSY_BIT  = OUT_REM_LSB + RES_W;
  localparam int unsigned OUT_PEAK_LSB  = OUT_BUSY_BIT + 1;
  localparam int unsigned OUT_TDATA_W   = 80;

  // 1.0 in Q16.8
  localparam logic signed [RES_W-1:0] ONE_Q8 = 25'sd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_MAX   = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

endpackage

>>> rtl/lslt_ram.sv
// ----------------------------------------------------------------------------
// Link slot load table RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lslt_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/link_slot_load_table_unit.sv
// ----------------------------------------------------------------------------
// Link slot load table unit
// Per-link, per-slot flow table with add, query and peak-read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: tuser carries the command, tdata the link, slot,
//   amount and capacity. Master channel m_axis_*: one result beat per input
//   beat, in order, with granted, remaining, busy flag and peak load.
//   An accepted beat issues reads of the slot load RAM and the link peak RAM;
//   the next cycle combines the read data and, once the output is free, an add
//   writes both back and the output register is loaded to offer the result.
//   Throughput is one beat per cycle unless the receiver stalls; back-to-back
//   beats to the same entry take the write-back value through a forwarding
//   register. After reset the slot load RAM is swept to zero, one entry per
//   cycle, over all NUM_LINKS * NUM_SLOTS entries (1024 with defaults),
//   and tready stays low then. The peak RAM needs no sweep: its entries count
//   only for links marked used, and the used flags are flip-flops cleared by
//   reset. When the receiver stalls, the output register holds; one more beat
//   can be taken into the RAM read stage and waits there until the output frees.
// ----------------------------------------------------------------------------
`include "link_slot_load_table_unit_defines.svh"

module link_slot_load_table_unit #(
  parameter int unsigned NUM_LINKS = lslt_pkg::NUM_LINKS_DEF,
  parameter int unsigned NUM_SLOTS = lslt_pkg::NUM_SLOTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // edge_index, slot_index, amount, capacity (from bit 0 up), zero padded
  input  logic [lslt_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // cmd
  input  logic [lslt_pkg::CMD_W-1:0]           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // granted, remaining, busy_res, peak_load (from bit 0 up), zero padded
  output logic [lslt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned DEPTH = NUM_LINKS * NUM_SLOTS;
  localparam int unsigned SA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LA_W  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int unsigned FW    = lslt_pkg::FLOW_W;
  localparam int unsigned RW    = lslt_pkg::RES_W;

  // input fields
  logic [lslt_pkg::EDGE_W-1:0] in_edge;
  logic [lslt_pkg::SLOT_W-1:0] in_slot;
  logic [FW-1:0]               in_amount;
  logic [FW-1:0]               in_cap;
  logic [31:0]                 in_saddr_full;
  logic [SA_W-1:0]             in_saddr;
  logic [LA_W-1:0]             in_link;
  logic                        in_link_ok;
  logic                        in_slot_ok;
  logic                        accept;

  // control
  lslt_pkg::state_e state_q, state_d;
  logic [SA_W-1:0]  clr_addr_q, clr_addr_d;
  logic             s1_q, s1_d;
  logic             s1_adv;
  logic             s1_wr;
  logic             out_valid_q, out_valid_d;
  logic [NUM_LINKS-1:0] used_q, used_d;

  // stage 1 payload
  lslt_pkg::cmd_e   s1_cmd_q;
  logic             s1_link_ok_q;
  logic             s1_slot_ok_q;
  logic [LA_W-1:0]  s1_link_q;
  logic [SA_W-1:0]  s1_saddr_q;
  logic [FW-1:0]    s1_amount_q;
  logic [FW-1:0]    s1_cap_q;
  logic             slot_hz_q, slot_hz_d;
  logic             peak_hz_q, peak_hz_d;
  logic [FW-1:0]    wb_load_q;
  logic [FW-1:0]    wb_peak_q;
  logic [lslt_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // RAM ports
  logic            slot_we;
  logic [SA_W-1:0] slot_waddr;
  logic [FW-1:0]   slot_wdata;
  logic [FW-1:0]   slot_rdata;
  logic [FW-1:0]   peak_rdata;

  // stage 1 datapath
  logic                 used;
  logic [FW-1:0]        load_rd;
  logic [FW-1:0]        peak_rd;
  logic [FW-1:0]        peak_eff;
  logic [FW:0]          sum;
  logic [FW-1:0]        sat_sum;
  logic [FW-1:0]        new_peak;
  logic [FW-1:0]        load_eff;
  logic signed [RW-1:0] rem;
  logic signed [RW-1:0] amt_s;
  logic signed [RW-1:0] grant;
  logic                 busy;

  assign in_edge   = s_axis_tdata_i[lslt_pkg::IN_EDGE_LSB +: lslt_pkg::EDGE_W];
  assign in_slot   = s_axis_tdata_i[lslt_pkg::IN_SLOT_LSB +: lslt_pkg::SLOT_W];
  assign in_amount = s_axis_tdata_i[lslt_pkg::IN_AMT_LSB +: FW];
  assign in_cap    = s_axis_tdata_i[lslt_pkg::IN_CAP_LSB +: FW];

  assign in_link_ok    = 32'(in_edge) < 32'(NUM_LINKS);
  assign in_slot_ok    = 32'(in_slot) < 32'(NUM_SLOTS);
  assign in_saddr_full = 32'(in_edge) * 32'(NUM_SLOTS) + 32'(in_slot);
  assign in_saddr      = in_saddr_full[SA_W-1:0];
  assign in_link       = LA_W'(in_edge);

  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == lslt_pkg::ST_RUN) && (!s1_q || s1_adv);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_wr           = s1_q && s1_adv && (s1_cmd_q == lslt_pkg::CMD_ADD)
                           && s1_link_ok_q && s1_slot_ok_q;

  // forward the write-back when the next beat reads the entry being written
  assign slot_hz_d = accept ? (s1_wr && (in_saddr == s1_saddr_q)) : slot_hz_q;
  assign peak_hz_d = accept ? (s1_wr && (in_link == s1_link_q)) : peak_hz_q;

  // clearing sweep
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      lslt_pkg::ST_CLEAR: begin
        clr_addr_d = clr_addr_q + SA_W'(1);
        if (clr_addr_q == SA_W'(DEPTH - 1)) begin
          state_d = lslt_pkg::ST_RUN;
        end
      end
      lslt_pkg::ST_RUN: begin
        state_d = lslt_pkg::ST_RUN;
      end
      default: begin
        state_d = lslt_pkg::ST_CLEAR;
      end
    endcase
  end

  assign slot_we    = (state_q == lslt_pkg::ST_CLEAR) || s1_wr;
  assign slot_waddr = (state_q == lslt_pkg::ST_CLEAR) ? clr_addr_q : s1_saddr_q;
  assign slot_wdata = (state_q == lslt_pkg::ST_CLEAR) ? '0 : sat_sum;

  lslt_ram #(
    .WIDTH (FW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (accept),
    .raddr_i (in_saddr),
    .rdata_o (slot_rdata)
  );

  lslt_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_LINKS)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (s1_wr),
    .waddr_i (s1_link_q),
    .wdata_i (new_peak),
    .re_i    (accept),
    .raddr_i (in_link),
    .rdata_o (peak_rdata)
  );

  // stage 1: combine read data
  always_comb begin
    used     = s1_link_ok_q && used_q[s1_link_q];
    load_rd  = slot_hz_q ? wb_load_q : slot_rdata;
    peak_rd  = peak_hz_q ? wb_peak_q : peak_rdata;
    peak_eff = used ? peak_rd : '0;
    sum      = {1'b0, load_rd} + {1'b0, s1_amount_q};
    sat_sum  = sum[FW] ? '1 : sum[FW-1:0];
    new_peak = (sat_sum > peak_eff) ? sat_sum : peak_eff;
    load_eff = (used && s1_slot_ok_q) ? load_rd : '0;
    rem      = $signed({1'b0, s1_cap_q}) - $signed({1'b0, load_eff});
    amt_s    = $signed({1'b0, s1_amount_q});
    grant    = (amt_s < rem) ? amt_s : rem;
    busy     = used && (grant < lslt_pkg::ONE_Q8);
  end

  always_comb begin
    out_data_d = '0;
    unique case (s1_cmd_q)
      lslt_pkg::CMD_ADD: begin
        out_data_d = '0;
      end
      lslt_pkg::CMD_QUERY: begin
        out_data_d[lslt_pkg::OUT_GRANT_LSB +: RW] = grant;
        out_data_d[lslt_pkg::OUT_REM_LSB +: RW]   = rem;
        out_data_d[lslt_pkg::OUT_BUSY_BIT]        = busy;
      end
      lslt_pkg::CMD_MAX: begin
        out_data_d[lslt_pkg::OUT_PEAK_LSB +: FW] = peak_eff;
      end
      default: begin
        out_data_d = '0;
      end
    endcase
  end

  always_comb begin
    used_d = used_q;
    if (s1_wr) begin
      used_d[s1_link_q] = 1'b1;
    end
  end

  assign s1_d        = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_q);
  assign out_valid_d = (s1_q && s1_adv) ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lslt_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      s1_q        <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      slot_hz_q   <= 1'b0;
      peak_hz_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      s1_q        <= s1_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      slot_hz_q   <= slot_hz_d;
      peak_hz_q   <= peak_hz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q     <= lslt_pkg::cmd_e'(s_axis_tuser_i);
      s1_link_ok_q <= in_link_ok;
      s1_slot_ok_q <= in_slot_ok;
      s1_link_q    <= in_link;
      s1_saddr_q   <= in_saddr;
      s1_amount_q  <= in_amount;
      s1_cap_q     <= in_cap;
    end
    if (s1_wr) begin
      wb_load_q <= sat_sum;
      wb_peak_q <= new_peak;
    end
    if (s1_q && s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `LSLT_ASSERT(a_no_accept_clear, (state_q == lslt_pkg::ST_CLEAR) |-> !s_axis_tready_o, "beat accepted during clear sweep")
  `LSLT_ASSERT(a_s1_to_out, (s1_q && s1_adv) |=> m_axis_tvalid_o, "stage 1 result lost")
  `LSLT_ASSERT(a_wr_in_run, s1_wr |-> (state_q == lslt_pkg::ST_RUN), "write-back during clear sweep")
  `LSLT_ASSERT(a_peak_ge_load, s1_wr |-> (new_peak >= sat_sum), "peak below slot load")

endmodule

>>> verif/lslt_flow_checker.sv
// ----------------------------------------------------------------------------
// Link slot load table: result checker
// Watches both stream channels of the unit, keeps its own copy of the per-slot
// flow table, per-link peak and used flags, predicts every result beat and
// compares it field by field against the beats that leave the unit.
// ----------------------------------------------------------------------------
module lslt_flow_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [lslt_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [lslt_pkg::CMD_W-1:0]       s_axis_tuser_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [lslt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  output int                               fail_count_o,
  output int                               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NL          = lslt_pkg::NUM_LINKS_DEF;
  localparam int unsigned NS          = lslt_pkg::NUM_SLOTS_DEF;
  localparam int unsigned TABLE_DEPTH = NL * NS;
  localparam int unsigned FW          = lslt_pkg::FLOW_W;
  localparam int unsigned RW          = lslt_pkg::RES_W;
  localparam int unsigned DW          = lslt_pkg::IN_TDATA_W;
  localparam logic [FW-1:0] FLOW_SAT  = '1;

  typedef struct packed {
    logic [RW-1:0] granted;
    logic [RW-1:0] remaining;
    logic          busy;
    logic [FW-1:0] peak;
  } slot_result_t;

  logic [FW-1:0]     slot_flow [TABLE_DEPTH];
  logic [FW-1:0]     link_top  [NL];
  logic              link_seen [NL];
  slot_result_t      result_q  [$];
  slot_result_t      want_r;
  slot_result_t      got_r;
  int                mismatch_count = 0;
  int                pending_count = 0;

  assign fail_count_o  = mismatch_count;
  assign outstanding_o = pending_count;

  task automatic flag_mismatch(input string what, input logic [RW-1:0] got,
                               input logic [RW-1:0] exp);
    $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, exp);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [RW-1:0] got,
                             input logic [RW-1:0] exp);
    if (got !== exp) flag_mismatch(what, got, exp);
  endtask

  // Apply one command beat to the shadow table and return its result.
  task automatic book_beat(input logic [lslt_pkg::CMD_W-1:0] cmd, input logic [DW-1:0] data,
                           output slot_result_t res);
    logic [lslt_pkg::EDGE_W-1:0] ln;
    logic [lslt_pkg::SLOT_W-1:0] sn;
    logic [FW-1:0]     amount;
    logic [FW-1:0]     cap;
    logic [FW-1:0]     load;
    logic [FW:0]       sum;
    logic              link_ok;
    logic              slot_ok;
    logic              used;
    int                idx;
    int                rem;
    int                grant;
    ln      = data[lslt_pkg::IN_EDGE_LSB +: lslt_pkg::EDGE_W];
    sn      = data[lslt_pkg::IN_SLOT_LSB +: lslt_pkg::SLOT_W];
    amount  = data[lslt_pkg::IN_AMT_LSB +: FW];
    cap     = data[lslt_pkg::IN_CAP_LSB +: FW];
    link_ok = ln < NL;
    slot_ok = sn < NS;
    idx     = int'(ln) * NS + int'(sn);
    res     = '0;
    case (cmd)
      lslt_pkg::CMD_ADD: begin
        if (link_ok && slot_ok) begin
          sum = {1'b0, slot_flow[idx]} + amount;
          if (sum[FW]) sum = {1'b0, FLOW_SAT};
          slot_flow[idx] = sum[FW-1:0];
          link_seen[ln]  = 1'b1;
          if (sum[FW-1:0] > link_top[ln]) link_top[ln] = sum[FW-1:0];
        end
      end
      lslt_pkg::CMD_QUERY: begin
        used = link_ok && link_seen[ln];
        load = (used && slot_ok) ? slot_flow[idx] : '0;
        rem  = int'(cap) - int'(load);
        // clip the request to what is left in the slot
        grant = int'(amount);
        if (rem < grant) grant = rem;
        res.granted   = grant[RW-1:0];
        res.remaining = rem[RW-1:0];
        res.busy      = used && (grant < lslt_pkg::ONE_Q8);
      end
      lslt_pkg::CMD_MAX: begin
        if (link_ok) res.peak = link_top[ln];
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_flow[i]) slot_flow[i] = '0;
      foreach (link_top[i]) link_top[i] = '0;
      foreach (link_seen[i]) link_seen[i] = 1'b0;
      result_q.delete();
      pending_count = 0;
    end else begin
      // retire the result beat first: it always belongs to an older command
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_r.granted   = m_axis_tdata_i[lslt_pkg::OUT_GRANT_LSB +: RW];
        got_r.remaining = m_axis_tdata_i[lslt_pkg::OUT_REM_LSB +: RW];
        got_r.busy      = m_axis_tdata_i[lslt_pkg::OUT_BUSY_BIT];
        got_r.peak      = m_axis_tdata_i[lslt_pkg::OUT_PEAK_LSB +: FW];
        if (result_q.size() == 0) begin
          flag_mismatch("result beat with no command outstanding", got_r.granted, '0);
        end else begin
          want_r = result_q.pop_front();
          check_field("granted", got_r.granted, want_r.granted);
          check_field("remaining", got_r.remaining, want_r.remaining);
          check_field("busy_res", RW'(got_r.busy), RW'(want_r.busy));
          check_field("peak_load", RW'(got_r.peak), RW'(want_r.peak));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        book_beat(s_axis_tuser_i, s_axis_tdata_i, want_r);
        result_q = {result_q, want_r};
      end
      pending_count = result_q.size();
    end
  end

endmodule

>>> verif/tb_link_slot_load_table_unit.sv
// ----------------------------------------------------------------------------
// Link slot load table unit: testbench top
// Resets the unit, lets it sweep its table, then sends a directed set of
// add, query and peak-read commands followed by random traffic concentrated
// on a few hot links. Sender bursts and receiver stalls vary throughout; the
// checker beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_link_slot_load_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = lslt_pkg::CMD_W;
  localparam int unsigned EW = lslt_pkg::EDGE_W;
  localparam int unsigned SW = lslt_pkg::SLOT_W;
  localparam int unsigned FW = lslt_pkg::FLOW_W;
  localparam logic [CW-1:0] CMD_RSVD = 2'd3;
  localparam logic [FW-1:0] FLOW_SAT = '1;
  localparam int RUN_ITEMS = 1250;
  localparam int DIRECTED_ITEMS = 21;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [lslt_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [CW-1:0]                    s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [lslt_pkg::OUT_TDATA_W-1:0] m_tdata;
  int                               fail_count;
  int                               outstanding;

  logic [EW-1:0] hot_link [4];
  logic [CW-1:0] rnd_cmd;
  logic [EW-1:0] rnd_link;
  logic [SW-1:0] rnd_slot;
  int            burst_left = 0;
  int            gap;
  int            pick;

  int          pat_hold = 0;
  logic [15:0] stall_pat = '1;
  bit          ready_free = 1'b1;

  always #6 clk_i = ~clk_i;

  link_slot_load_table_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  lslt_flow_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // Receiver: rotate a stall pattern, reloaded now and then; some stretches
  // never stall. Bits 0 and 8 stay set so each half of the pattern has a ready bit.
  always @(negedge clk_i) begin
    if (pat_hold == 0) begin
      pat_hold   = $urandom_range(20, 300);
      ready_free = ($urandom_range(0, 3) == 0);
      stall_pat  = 16'($urandom) | 16'h0101;
    end
    pat_hold--;
    m_tready <= ready_free || stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic put_beat(input logic [CW-1:0] cmd, input logic [EW-1:0] ln,
                          input logic [SW-1:0] sn, input logic [FW-1:0] amount,
                          input logic [FW-1:0] cap);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= lslt_pkg::IN_TDATA_W'({cap, amount, sn, ln});
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [FW-1:0] pick_flow();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FLOW_SAT;
      2:       return FW'($urandom_range(0, 1023));
      3:       return FW'($urandom >> $urandom_range(8, 31));
      default: return FW'($urandom);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unused link: full capacity, never busy
    put_beat(lslt_pkg::CMD_QUERY, 6'd5, 4'd3, 24'h000300, 24'h000200);
    put_beat(lslt_pkg::CMD_QUERY, 6'd5, 4'd3, 24'h000000, 24'h000000);
    put_beat(lslt_pkg::CMD_MAX, 6'd5, 4'd0, '0, '0);
    // add of zero still marks the link used
    put_beat(lslt_pkg::CMD_ADD, 6'd5, 4'd3, 24'h000000, '0);
    put_beat(lslt_pkg::CMD_QUERY, 6'd5, 4'd3, 24'h000000, FLOW_SAT);
    put_beat(lslt_pkg::CMD_MAX, 6'd5, 4'd0, '0, '0);
    // saturate the top link and slot
    put_beat(lslt_pkg::CMD_ADD, 6'd63, 4'd15, FLOW_SAT, '0);
    put_beat(lslt_pkg::CMD_ADD, 6'd63, 4'd15, 24'h000100, '0);
    put_beat(lslt_pkg::CMD_MAX, 6'd63, 4'd0, '0, '0);
    put_beat(lslt_pkg::CMD_QUERY, 6'd63, 4'd15, FLOW_SAT, 24'h000000);
    put_beat(lslt_pkg::CMD_QUERY, 6'd63, 4'd15, FLOW_SAT, FLOW_SAT);
    // busy threshold at 1.0 on a used link
    put_beat(lslt_pkg::CMD_QUERY, 6'd63, 4'd0, 24'h0001FF, 24'h000100);
    put_beat(lslt_pkg::CMD_QUERY, 6'd63, 4'd0, 24'h0001FF, 24'h0000FF);
    // back-to-back adds to one entry
    put_beat(lslt_pkg::CMD_ADD, 6'd0, 4'd0, 24'h000001, '0);
    put_beat(lslt_pkg::CMD_ADD, 6'd0, 4'd0, 24'h000002, '0);
    put_beat(lslt_pkg::CMD_QUERY, 6'd0, 4'd0, 24'h000010, 24'h000005);
    // a smaller load later must not lower the peak
    put_beat(lslt_pkg::CMD_ADD, 6'd0, 4'd7, 24'h123456, '0);
    put_beat(lslt_pkg::CMD_ADD, 6'd0, 4'd1, 24'h000010, '0);
    put_beat(lslt_pkg::CMD_MAX, 6'd0, 4'd0, '0, '0);
    put_beat(CMD_RSVD, 6'd63, 4'd15, FLOW_SAT, FLOW_SAT);
    put_beat(lslt_pkg::CMD_QUERY, 6'd0, 4'd7, 24'h000400, FLOW_SAT);

    for (int n = 0; n < RUN_ITEMS - DIRECTED_ITEMS; n++) begin
      // move the hot set now and then so fresh entries fill up again
      if (n % 200 == 0) begin
        foreach (hot_link[i]) hot_link[i] = EW'($urandom);
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;

      pick     = $urandom_range(0, 99);
      rnd_cmd  = (pick < 40) ? lslt_pkg::CMD_ADD
               : (pick < 82) ? lslt_pkg::CMD_QUERY
               : (pick < 96) ? lslt_pkg::CMD_MAX
                             : CMD_RSVD;
      rnd_link = ($urandom_range(0, 3) != 0) ? hot_link[$urandom_range(0, 3)]
                                             : EW'($urandom);
      rnd_slot = ($urandom_range(0, 1) != 0) ? SW'($urandom_range(0, 3))
                                             : SW'($urandom);
      put_beat(rnd_cmd, rnd_link, rnd_slot, pick_flow(), pick_flow());
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lslt_pkg.sv
rtl/lslt_ram.sv
rtl/link_slot_load_table_unit.sv
verif/lslt_flow_checker.sv
verif/tb_link_slot_load_table_unit.sv
